>>> rtl/multi_reader_record_ring_assert.svh
// Assertion macros for the record ring checker.
// Depends on a clk and arst_n in the scope of each use.
`ifndef MULTI_READER_RECORD_RING_ASSERT_SVH
`define MULTI_READER_RECORD_RING_ASSERT_SVH

// Same-cycle implication, quiet during reset
`define MRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset
`define MRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mrr_pkg.sv
// Shared types and constants for the multi-reader record ring.
// No dependencies.
`timescale 1ns / 1ps
package mrr_pkg;

	localparam int RING_WORDS_DEF  = 1024;
	localparam int MAX_READERS_DEF = 8;
	localparam int MAX_LEN_DEF     = 64;

	localparam int RING_SIZE_W = 11;
	localparam int NUM_RDR_W   = 4;
	localparam int ELEM_W      = 32;
	localparam int AGENT_W     = 3;
	localparam int LEN_W       = 7;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RING_SIZE   = 1'b0,
		CFG_NUM_READERS = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_EV_TEST,
		ST_EV_STEP,
		ST_WR_AGENT,
		ST_WR_LEN,
		ST_WR_ELEM,
		ST_RD_TEST,
		ST_RD_HDR,
		ST_RD_LEN,
		ST_RD_EL,
		ST_RD_EO,
		ST_NF
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_EV_TEST,
		OP_EV_STEP,
		OP_WR_AGENT,
		OP_WR_LEN,
		OP_WR_ELEM,
		OP_RD_TEST,
		OP_RD_HDR,
		OP_RD_LEN,
		OP_RD_EL,
		OP_RD_EO,
		OP_NF
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic clr_done;
		logic is_write;
		logic is_first;
		logic rd_bad;
		logic ev_done;
		logic ev_need;
		logic rd_end;
		logic giveup;
		logic own;
		logic hl_zero;
		logic cnt_last;
	} stat_t;

endpackage

>>> rtl/mrr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module mrr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/mrr_ctrl.sv
// Controller state machine of the record ring.
// Depends on mrr_pkg.
`timescale 1ns / 1ps
module mrr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mrr_pkg::stat_t stat,
	output mrr_pkg::cmd_t  cmd,
	output logic          busy
);
	import mrr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (stat.clr_done) state_d = ST_IDLE;
			ST_IDLE:     if (start) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (stat.is_write) state_d = stat.is_first ? ST_EV_TEST : ST_WR_ELEM;
				else               state_d = stat.rd_bad ? ST_NF : ST_RD_TEST;
			end
			ST_EV_TEST: begin
				if (stat.ev_done)      state_d = ST_WR_AGENT;
				else if (stat.ev_need) state_d = ST_EV_STEP;
			end
			ST_EV_STEP:  state_d = ST_EV_TEST;
			ST_WR_AGENT: state_d = ST_WR_LEN;
			ST_WR_LEN:   state_d = ST_WR_ELEM;
			ST_WR_ELEM:  state_d = ST_IDLE;
			ST_RD_TEST:  state_d = (stat.rd_end || stat.giveup) ? ST_NF : ST_RD_HDR;
			ST_RD_HDR:   state_d = ST_RD_LEN;
			ST_RD_LEN: begin
				if (stat.own)          state_d = ST_RD_TEST;
				else if (stat.hl_zero) state_d = ST_IDLE;
				else                   state_d = ST_RD_EL;
			end
			ST_RD_EL:    state_d = ST_RD_EO;
			ST_RD_EO:    if (stat.cnt_last) state_d = ST_IDLE;
			ST_NF:       state_d = ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
		// a register write restarts the clearing pass
		if (stat.cfg_hit) state_d = ST_CLEAR;
	end

	// command outputs
	always_comb begin
		cmd.op = OP_NONE;
		busy   = 1'b1;
		case (state_q)
			ST_CLEAR:    cmd.op = OP_CLEAR;
			ST_IDLE: begin
				busy = 1'b0;
				if (start) cmd.op = OP_LOAD;
			end
			ST_DISPATCH: cmd.op = OP_NONE;
			ST_EV_TEST:  cmd.op = OP_EV_TEST;
			ST_EV_STEP:  cmd.op = OP_EV_STEP;
			ST_WR_AGENT: cmd.op = OP_WR_AGENT;
			ST_WR_LEN:   cmd.op = OP_WR_LEN;
			ST_WR_ELEM:  cmd.op = OP_WR_ELEM;
			ST_RD_TEST:  cmd.op = OP_RD_TEST;
			ST_RD_HDR:   cmd.op = OP_RD_HDR;
			ST_RD_LEN:   cmd.op = OP_RD_LEN;
			ST_RD_EL:    cmd.op = OP_RD_EL;
			ST_RD_EO:    cmd.op = OP_RD_EO;
			ST_NF:       cmd.op = OP_NF;
			default:     cmd.op = OP_NONE;
		endcase
	end
endmodule

>>> rtl/mrr_datapath.sv
// Datapath of the record ring: ring memory, heads, tail, registers, results.
// Depends on mrr_pkg and mrr_ram.
`timescale 1ns / 1ps
module mrr_datapath #(
	parameter int RING_WORDS  = mrr_pkg::RING_WORDS_DEF,
	parameter int MAX_READERS = mrr_pkg::MAX_READERS_DEF,
	parameter int MAX_LEN     = mrr_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mrr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mrr_pkg::RING_SIZE_W-1:0] cfg_wdata,
	input  logic                          func,
	input  logic [mrr_pkg::AGENT_W-1:0]     agent_id,
	input  logic [mrr_pkg::LEN_W-1:0]       record_length,
	input  logic [mrr_pkg::ELEM_W-1:0]      element,
	input  logic                          first_elem,
	input  logic                          last_elem,
	input  mrr_pkg::cmd_t                  cmd,
	output mrr_pkg::stat_t                 stat,
	output logic                          result_valid,
	output logic                          found,
	output logic [mrr_pkg::AGENT_W-1:0]     source_agent,
	output logic [mrr_pkg::ELEM_W-1:0]      value_out,
	output logic                          last_out
);
	import mrr_pkg::*;

	localparam int DEPTH = RING_WORDS + MAX_LEN + 2;
	localparam int RAW   = $clog2(DEPTH);
	localparam int AW    = $clog2(DEPTH + 1);
	localparam int RIW   = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
	localparam int RCW   = $clog2(MAX_READERS + 1);
	localparam int TW    = $clog2(RING_WORDS + 2);
	localparam int CW    = $clog2(MAX_LEN + 1);
	localparam int SPW   = AW + 8;
	localparam int SUMW  = ELEM_W + 2;
	localparam int RS_RST = (RING_WORDS < 1024) ? RING_WORDS : 1024;
	localparam int NR_RST = (MAX_READERS < 8) ? MAX_READERS : 8;

	// configuration and ring state
	logic [AW-1:0]        ring_size_q;
	logic [NUM_RDR_W-1:0] num_rdr_q;
	logic [AW-1:0]        head_q [MAX_READERS];
	logic                 at_end_q [MAX_READERS];
	logic [AW-1:0]        tail_q;
	logic [RAW-1:0]       clr_q;

	// latched item and walk state
	logic                 func_q, first_q, last_q;
	logic [AGENT_W-1:0]   agent_q;
	logic [LEN_W-1:0]     len_q;
	logic [ELEM_W-1:0]    elem_q;
	logic [RCW-1:0]       idx_q;
	logic [TW-1:0]        tries_q;
	logic [ELEM_W-1:0]    hdr0_q;
	logic [RAW-1:0]       ea_q;
	logic [CW-1:0]        cnt_q;

	// memory port
	logic                 ram_we;
	logic [RAW-1:0]       ram_waddr, ram_raddr;
	logic [ELEM_W-1:0]    ram_wdata, ram_rdata;

	logic [RIW-1:0]       rdr_sel;
	logic [AW-1:0]        head_sel, step_nxt, tail_inc;
	logic [SPW-1:0]       span;
	logic [SUMW-1:0]      step_sum;
	logic [LEN_W-1:0]     len_sat;
	logic [RING_SIZE_W-1:0] rs_v;
	logic [NUM_RDR_W-1:0] nr_v;

	mrr_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one head port: eviction walks by index, reads by agent
	assign rdr_sel  = func_q ? RIW'(agent_q) : idx_q[RIW-1:0];
	assign head_sel = head_q[rdr_sel];

	// next record start from a header at head_sel, length word on ram_rdata
	assign step_sum = SUMW'(head_sel) + SUMW'(2) + SUMW'(ram_rdata);
	always_comb begin
		if (32'(head_sel) + 1 >= DEPTH)               step_nxt = '0;
		else if (step_sum >= SUMW'(ring_size_q))      step_nxt = '0;
		else                                          step_nxt = step_sum[AW-1:0];
	end

	assign span     = SPW'(tail_q) + SPW'(len_q) + SPW'(2);
	assign tail_inc = (32'(tail_q) < DEPTH) ? tail_q + AW'(1) : tail_q;

	// status to the controller
	always_comb begin
		stat.cfg_hit  = cfg_we;
		stat.clr_done = (clr_q == RAW'(DEPTH - 1));
		stat.is_write = !func_q;
		stat.is_first = first_q;
		stat.rd_bad   = (32'(agent_q) >= 32'(num_rdr_q));
		stat.ev_done  = (32'(idx_q) >= 32'(num_rdr_q));
		stat.ev_need  = (tail_q < head_sel) && (SPW'(head_sel) < span);
		stat.rd_end   = (head_sel == tail_q) && at_end_q[rdr_sel];
		stat.giveup   = (32'(tries_q) > RING_WORDS);
		stat.own      = (hdr0_q == ELEM_W'(agent_q));
		stat.hl_zero  = (ram_rdata == '0);
		stat.cnt_last = (cnt_q == CW'(1));
	end

	// memory access per command
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = tail_q[RAW-1:0];
		ram_wdata = elem_q;
		ram_raddr = '0;
		case (cmd.op)
			OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			OP_WR_AGENT: begin
				ram_we    = (32'(tail_q) < DEPTH);
				ram_wdata = ELEM_W'(agent_q);
			end
			OP_WR_LEN: begin
				ram_we    = (32'(tail_q) < DEPTH);
				ram_wdata = ELEM_W'(len_q);
			end
			OP_WR_ELEM: ram_we = (32'(tail_q) < DEPTH);
			OP_EV_TEST: ram_raddr = RAW'(head_sel + AW'(1));
			OP_RD_TEST: ram_raddr = head_sel[RAW-1:0];
			OP_RD_HDR:  ram_raddr = RAW'(head_sel + AW'(1));
			OP_RD_EL, OP_RD_EO: ram_raddr = ea_q;
			default: ram_raddr = '0;
		endcase
	end

	// saturated inputs
	always_comb begin
		len_sat = record_length;
		if (record_length < LEN_W'(1))             len_sat = LEN_W'(1);
		else if (32'(record_length) > MAX_LEN)     len_sat = LEN_W'(MAX_LEN);
		rs_v = cfg_wdata;
		if (cfg_wdata < RING_SIZE_W'(8))           rs_v = RING_SIZE_W'(8);
		else if (32'(cfg_wdata) > RING_WORDS)      rs_v = RING_SIZE_W'(RING_WORDS);
		nr_v = cfg_wdata[NUM_RDR_W-1:0];
		if (nr_v < NUM_RDR_W'(1))                  nr_v = NUM_RDR_W'(1);
		else if (32'(nr_v) > MAX_READERS)          nr_v = NUM_RDR_W'(MAX_READERS);
	end

	// control state: registers, heads, flags, tail, counters, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q  <= AW'(RS_RST);
			num_rdr_q    <= NUM_RDR_W'(NR_RST);
			tail_q       <= '0;
			clr_q        <= '0;
			idx_q        <= '0;
			tries_q      <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
			for (int i = 0; i < MAX_READERS; i++) begin
				head_q[i]   <= '0;
				at_end_q[i] <= 1'b1;
			end
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RING_SIZE:   ring_size_q <= AW'(rs_v);
					CFG_NUM_READERS: num_rdr_q   <= nr_v;
					default: ;
				endcase
				tail_q <= '0;
				clr_q  <= '0;
				for (int i = 0; i < MAX_READERS; i++) begin
					head_q[i]   <= '0;
					at_end_q[i] <= 1'b1;
				end
			end else begin
				case (cmd.op)
					OP_CLEAR: clr_q <= clr_q + RAW'(1);
					OP_LOAD: begin
						idx_q   <= '0;
						tries_q <= '0;
					end
					OP_EV_TEST: begin
						if (!stat.ev_done && !stat.ev_need) begin
							at_end_q[rdr_sel] <= 1'b0;
							idx_q             <= idx_q + RCW'(1);
						end
					end
					OP_EV_STEP: head_q[rdr_sel] <= step_nxt;
					OP_WR_AGENT, OP_WR_LEN: tail_q <= tail_inc;
					OP_WR_ELEM: begin
						if (last_q && tail_inc >= ring_size_q) tail_q <= '0;
						else                                   tail_q <= tail_inc;
					end
					OP_RD_TEST: begin
						if (!stat.rd_end && !stat.giveup) tries_q <= tries_q + TW'(1);
					end
					OP_RD_LEN: begin
						head_q[rdr_sel]   <= step_nxt;
						at_end_q[rdr_sel] <= (step_nxt == tail_q);
						cnt_q <= (32'(ram_rdata) > MAX_LEN) ? CW'(MAX_LEN)
						                                    : ram_rdata[CW-1:0];
						if (!stat.own && stat.hl_zero) result_valid <= 1'b1;
					end
					OP_RD_EO: begin
						cnt_q        <= cnt_q - CW'(1);
						result_valid <= 1'b1;
					end
					OP_NF: result_valid <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				func_q  <= func;
				agent_q <= agent_id;
				len_q   <= len_sat;
				elem_q  <= element;
				first_q <= first_elem;
				last_q  <= last_elem;
			end
			OP_RD_HDR: hdr0_q <= ram_rdata;
			OP_RD_LEN: begin
				ea_q         <= RAW'(head_sel + AW'(2));
				found        <= 1'b1;
				source_agent <= hdr0_q[AGENT_W-1:0];
				value_out    <= '0;
				last_out     <= 1'b1;
			end
			OP_RD_EL: ea_q <= ea_q + RAW'(1);
			OP_RD_EO: begin
				ea_q         <= ea_q + RAW'(1);
				found        <= 1'b1;
				source_agent <= hdr0_q[AGENT_W-1:0];
				value_out    <= ram_rdata;
				last_out     <= stat.cnt_last;
			end
			OP_NF: begin
				found        <= 1'b0;
				source_agent <= '0;
				value_out    <= '0;
				last_out     <= 1'b1;
			end
			default: ;
		endcase
	end
endmodule

>>> rtl/multi_reader_record_ring.sv
// Multi-reader record ring: command-style top level.
// A write element stores its word; a first element first moves each active reader's head
// past the records it would overwrite, then writes the agent and length header words.
// A read walks record headers; elements of one read come out one per cycle.
// After reset or any register write, a clearing pass zeroes all RING_WORDS+MAX_LEN+2
// ring words while busy is high. The receiver cannot stall results.
`timescale 1ns / 1ps
module multi_reader_record_ring #(
	parameter int RING_WORDS  = mrr_pkg::RING_WORDS_DEF,
	parameter int MAX_READERS = mrr_pkg::MAX_READERS_DEF,
	parameter int MAX_LEN     = mrr_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cfg_we,
	input  logic [mrr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mrr_pkg::RING_SIZE_W-1:0] cfg_wdata,
	input  logic                          func,
	input  logic [mrr_pkg::AGENT_W-1:0]     agent_id,
	input  logic [mrr_pkg::LEN_W-1:0]       record_length,
	input  logic [mrr_pkg::ELEM_W-1:0]      element,
	input  logic                          first_elem,
	input  logic                          last_elem,
	output logic                          result_valid,
	output logic                          found,
	output logic [mrr_pkg::AGENT_W-1:0]     source_agent,
	output logic [mrr_pkg::ELEM_W-1:0]      value_out,
	output logic                          last_out
);
	import mrr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mrr_datapath #(
		.RING_WORDS  (RING_WORDS),
		.MAX_READERS (MAX_READERS),
		.MAX_LEN     (MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.func          (func),
		.agent_id      (agent_id),
		.record_length (record_length),
		.element       (element),
		.first_elem    (first_elem),
		.last_elem     (last_elem),
		.cmd           (cmd),
		.stat          (stat),
		.result_valid  (result_valid),
		.found         (found),
		.source_agent  (source_agent),
		.value_out     (value_out),
		.last_out      (last_out)
	);
endmodule

>>> rtl/mrr_checker.sv
// Port-level checks of the record ring, bound to the top level.
// Depends on mrr_pkg and multi_reader_record_ring_assert.svh.
`timescale 1ns / 1ps
`include "multi_reader_record_ring_assert.svh"
module mrr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      result_valid,
	input logic                      found,
	input logic [mrr_pkg::AGENT_W-1:0] source_agent,
	input logic [mrr_pkg::ELEM_W-1:0]  value_out,
	input logic                      last_out
);
	import mrr_pkg::*;

	// a not-found beat is a lone, final, empty beat
	`MRR_ASSERT_NOW(a_nf_last, result_valid && !found, last_out, "not-found beat without last")
	`MRR_ASSERT_NOW(a_nf_zero, result_valid && !found, source_agent == '0 && value_out == '0, "not-found beat carries data")
	// an accepted item always keeps the block busy next cycle
	`MRR_ASSERT_NEXT(a_busy, start && !busy, busy, "accepted item left block idle")
	// the final beat of a read is never followed at once by another beat
	`MRR_ASSERT_NEXT(a_gap, result_valid && last_out, !result_valid, "beat right after last beat")
endmodule

bind multi_reader_record_ring mrr_checker u_mrr_checker (.*);

>>> dv/multi_reader_record_ring_test.sv
// Self-checking testbench for the multi-reader record ring.
// Depends on mrr_pkg and multi_reader_record_ring; a built-in predictor tracks ring state.
`timescale 1ns / 1ps
module multi_reader_record_ring_test;
	import mrr_pkg::*;

	localparam int DEPTH = RING_WORDS_DEF + MAX_LEN_DEF + 2;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		bit        found;
		bit [2:0]  src;
		bit [31:0] value;
		bit        last;
	} ring_beat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_RING_SIZE;
	logic [RING_SIZE_W-1:0] cfg_wdata = '0;
	logic func = 0;
	logic [AGENT_W-1:0] agent_id = '0;
	logic [LEN_W-1:0] record_length = '0;
	logic [ELEM_W-1:0] element = '0;
	logic first_elem = 0;
	logic last_elem = 0;
	logic result_valid, found, last_out;
	logic [AGENT_W-1:0] source_agent;
	logic [ELEM_W-1:0] value_out;

	// predictor state
	bit [31:0] ring_mem [DEPTH];
	int unsigned heads [MAX_READERS_DEF];
	bit at_end [MAX_READERS_DEF];
	int unsigned tail, ring_lim, readers;

	ring_beat_t pending_beats [$];
	int errors = 0, beats_checked = 0, items_sent = 0, cfg_writes = 0;
	int cycles = 0, burst_left = 0;

	multi_reader_record_ring uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.func(func), .agent_id(agent_id), .record_length(record_length),
		.element(element), .first_elem(first_elem), .last_elem(last_elem),
		.result_valid(result_valid), .found(found), .source_agent(source_agent),
		.value_out(value_out), .last_out(last_out)
	);

	always #1 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic void clear_ring();
		foreach (ring_mem[i]) ring_mem[i] = '0;
		for (int i = 0; i < MAX_READERS_DEF; i++) begin
			heads[i] = 0;
			at_end[i] = 1;
		end
		tail = 0;
	endfunction

	function automatic void apply_cfg(cfg_reg_t idx, int unsigned val);
		int unsigned v;
		if (idx == CFG_RING_SIZE) begin
			v = val & 11'h7FF;
			if (v < 8) v = 8;
			if (v > RING_WORDS_DEF) v = RING_WORDS_DEF;
			ring_lim = v;
		end else begin
			v = val & 4'hF;
			if (v < 1) v = 1;
			if (v > MAX_READERS_DEF) v = MAX_READERS_DEF;
			readers = v;
		end
		clear_ring();
	endfunction

	function automatic int unsigned next_record(int unsigned p);
		longint unsigned n;
		if (p + 1 >= DEPTH) return 0;
		n = longint'(p) + 2 + longint'(ring_mem[p + 1]);
		return (n >= ring_lim) ? 0 : int'(n);
	endfunction

	function automatic void store_word(bit [31:0] v);
		if (tail < DEPTH) begin
			ring_mem[tail] = v;
			tail++;
		end
	endfunction

	function automatic void push_beat(bit f, bit [2:0] s, bit [31:0] v, bit l);
		ring_beat_t b;
		b.found = f; b.src = s; b.value = v; b.last = l;
		pending_beats = {pending_beats, b};
	endfunction

	function automatic void predict_item(bit fn, bit [2:0] ag, bit [6:0] len,
			bit [31:0] el, bit fe, bit le);
		int unsigned l, pos, tries, hl, cnt, adr;
		longint unsigned span;
		bit own;
		if (fn == 1'b0) begin
			if (fe) begin
				l = len;
				if (l < 1) l = 1;
				if (l > MAX_LEN_DEF) l = MAX_LEN_DEF;
				span = longint'(tail) + l + 2;
				// push forward every head inside the window about to be overwritten
				for (int i = 0; i < readers; i++) begin
					while (tail < heads[i] && heads[i] < span)
						heads[i] = next_record(heads[i]);
					at_end[i] = 0;
				end
				store_word(ag);
				store_word(l);
			end
			store_word(el);
			if (le && tail >= ring_lim) tail = 0;
			return;
		end
		if (ag >= readers) begin
			push_beat(0, 0, 0, 1);
			return;
		end
		tries = 0;
		pos = heads[ag];
		// walk headers, skipping the reader's own records
		while (pos != tail || !at_end[ag]) begin
			if (tries > RING_WORDS_DEF || pos >= DEPTH) begin
				push_beat(0, 0, 0, 1);
				return;
			end
			tries++;
			own = (ring_mem[pos] == ag);
			heads[ag] = next_record(pos);
			at_end[ag] = (heads[ag] == tail);
			if (!own) begin
				hl = (pos + 1 < DEPTH) ? ring_mem[pos + 1] : 0;
				if (hl == 0) begin
					push_beat(1, ring_mem[pos][2:0], 0, 1);
					return;
				end
				cnt = (hl > MAX_LEN_DEF) ? MAX_LEN_DEF : hl;
				for (int k = 0; k < cnt; k++) begin
					adr = pos + 2 + k;
					push_beat(1, ring_mem[pos][2:0], (adr < DEPTH) ? ring_mem[adr] : 0,
						k + 1 == cnt);
				end
				return;
			end
			pos = heads[ag];
		end
		push_beat(0, 0, 0, 1);
	endfunction

	// ---------------- result checking ----------------
	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		ring_beat_t w;
		if (arst_n && result_valid) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat", value_out, 0);
			end else begin
				w = pending_beats.pop_front();
				beats_checked++;
				if (found !== w.found) report_mismatch("found", found, w.found);
				if (source_agent !== w.src) report_mismatch("source_agent", source_agent, w.src);
				if (value_out !== w.value) report_mismatch("value_out", value_out, w.value);
				if (last_out !== w.last) report_mismatch("last_out", last_out, w.last);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	// called at a rising edge; start is left high for a back-to-back item
	task automatic send_item(bit fn, bit [2:0] ag, bit [6:0] len, bit [31:0] el,
			bit fe, bit le);
		start <= 1;
		func <= fn; agent_id <= ag; record_length <= len;
		element <= el; first_elem <= fe; last_elem <= le;
		do @(posedge clk); while (busy);
		predict_item(fn, ag, len, el, fe, le);
		items_sent++;
		// bursts with random gaps between them
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_record(bit [2:0] ag, bit [6:0] len);
		int n;
		n = (len < 1) ? 1 : (len > MAX_LEN_DEF) ? MAX_LEN_DEF : len;
		for (int k = 0; k < n; k++)
			send_item(0, ag, len, $urandom, k == 0, k == n - 1);
	endtask

	task automatic wait_drained();
		start <= 0;
		@(posedge clk);
		while (pending_beats.size() != 0 || busy) @(posedge clk);
		// a write beat leaves no result; give the last one time to retire
		repeat (20) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, bit [10:0] val);
		wait_drained();
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		apply_cfg(idx, val);
		cfg_writes++;
		repeat (2) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// ---------------- tests ----------------
	task automatic test_basic_records();
		send_item(1, 0, 0, 0, 0, 0);                     // empty ring: not found
		send_item(0, 1, 2, 32'h0000_0000, 1, 0);
		send_item(0, 1, 2, 32'hFFFF_FFFF, 0, 1);
		send_item(1, 0, 0, 0, 0, 0);                     // foreign record
		send_item(1, 1, 0, 0, 0, 0);                     // own record skipped
		send_item(0, 7, 0, 32'hA5A5_5A5A, 1, 1);         // zero length saturates up
		send_item(1, 2, 0, 0, 0, 0);
		send_item(1, 2, 0, 0, 0, 0);
		send_item(0, 3, 7'h7F, 32'h1234_5678, 0, 0);     // stray element, no header
		send_item(1, 3, 0, 0, 0, 0);
	endtask

	task automatic test_bad_reader();
		write_record(2, 3);
		send_item(1, 7, 0, 0, 0, 0);                     // reader beyond count
		send_item(1, 3, 0, 0, 0, 0);
		send_item(1, 0, 0, 0, 0, 0);
	endtask

	task automatic test_small_ring();
		write_record(0, 3);
		write_record(0, 2);                              // wraps
		send_item(1, 0, 0, 0, 0, 0);
		write_record(0, 4);
	endtask

	task automatic test_random(int count);
		int target, r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				if ($urandom_range(0, 19) == 0)
					write_record(3'($urandom_range(0, 7)),
						($urandom_range(0, 1)) ? 7'd64 : 7'd127);
				else
					write_record(3'($urandom_range(0, 7)), 7'($urandom_range(0, 6)));
			end else if (r < 90) begin
				send_item(1, 3'($urandom_range(0, 7)), 7'($urandom), $urandom,
					1'($urandom), 1'($urandom));
			end else begin
				send_item(0, 3'($urandom_range(0, 7)), 7'($urandom), $urandom,
					1'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic test_quiesce_then_read();
		wait_drained();
		for (int a = 0; a < 8; a++) send_item(1, 3'(a), 0, 0, 0, 0);
	endtask

	initial begin
		ring_lim = RING_WORDS_DEF;
		readers = MAX_READERS_DEF;
		clear_ring();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		test_basic_records();
		test_random(20);
		test_quiesce_then_read();

		write_cfg(CFG_NUM_READERS, 11'd3);
		write_cfg(CFG_RING_SIZE, 11'd40);
		test_bad_reader();
		test_random(20);

		write_cfg(CFG_RING_SIZE, 11'd0);                 // saturates to minimum
		write_cfg(CFG_NUM_READERS, 11'd0);               // saturates to one reader
		test_small_ring();
		test_random(15);

		write_cfg(CFG_RING_SIZE, 11'h7FF);               // saturates to maximum
		write_cfg(CFG_NUM_READERS, 11'h7FF);
		test_random(25);

		wait_drained();
		repeat (50) @(posedge clk);
		$display("covered %0d items, %0d result beats, %0d register writes", items_sent,
			beats_checked, cfg_writes);
		$display("ring sizes 8/40/1024, reader counts 1/3/8, saturation and wrap cases");
		if (errors == 0 && pending_beats.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/mrr_pkg.sv
rtl/mrr_ram.sv
rtl/mrr_ctrl.sv
rtl/mrr_datapath.sv
rtl/multi_reader_record_ring.sv
rtl/mrr_checker.sv
dv/multi_reader_record_ring_test.sv
